// ===== src/hwmf_pkg.sv =====
// hwmf_pkg: shared types and codes for the haplotype window mismatch finder.
// No dependencies; used by the top, hwmf_ctrl and hwmf_dp (not hwmf_ram).
`timescale 1ns / 1ps
`default_nettype none

package hwmf_pkg;

    localparam int TRACK_W = 32;   // width of one track field on the item
    localparam int SAMPLE_W = 5;
    localparam int INDEX_W = 6;
    localparam int STATUS_W = 3;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_COMPARE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MISMATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

    typedef struct packed {
        logic [1:0]          command;
        logic [TRACK_W-1:0]  first_track_bits;
        logic [TRACK_W-1:0]  second_track_bits;
        logic [SAMPLE_W-1:0] sample_one;
        logic                track_one;
        logic [SAMPLE_W-1:0] sample_two;
        logic                track_two;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  site_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // item transfer this cycle
        logic walk;     // compare walk running
        logic flush;    // emit the closing compare result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;     // output register can take a result
        logic walk_done;    // all sites read and checked
        logic is_compare;   // offered item is a compare
    } stat_t;

endpackage

`default_nettype wire

// ===== src/haplotype_window_mismatch_finder_top.sv =====
// Latency: append/remove give their one result the cycle after the transfer.
// Compare: held sites are read one per cycle from the site store (one RAM read
// port) unless a mismatch waits on a stalled result side; the input stays closed
// through the walk and its closing result, and the non-final mismatch results
// stream out during the walk.
// Throughput: one item at a time; next item taken once idle and output free.
// Reset (rst_n, async, active low) empties the window; store contents stay.
`timescale 1ns / 1ps
`default_nettype none

module haplotype_window_mismatch_finder_top #(
    parameter int NUM_SAMPLES = 32,
    parameter int WINDOW_SITES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire hwmf_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output hwmf_pkg::result_t      result
);

    // Controller decides when an item transfers and sequences the compare
    // walk and its closing result; the datapath holds the window pointers,
    // the site store and the output register.
    hwmf_pkg::ctl_t  ctl;
    hwmf_pkg::stat_t stat;

    hwmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Mismatches are held back one deep so that the last one found can be
    // flagged; an empty or clean compare closes with a no-mismatch result.
    hwmf_dp #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .WINDOW_SITES(WINDOW_SITES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .ctl         (ctl),
        .stat        (stat),
        .result      (result),
        .result_valid(result_valid),
        .result_ready(result_ready)
    );

    // no new item while a compare walk or its closing result is pending
    a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.walk || ctl.flush) |-> !item_ready)
        else $error("item ready during compare");

    // only mismatch results may be non-final
    a_nonlast_is_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (result.status == hwmf_pkg::ST_MISMATCH))
        else $error("non-final result that is not a mismatch");

    // site index is zero on every result that is not a mismatch
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != hwmf_pkg::ST_MISMATCH))
        |-> (result.site_index == '0))
        else $error("nonzero site index on non-mismatch result");

    // a closing result always lands in the output register next cycle
    a_flush_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |=> (result_valid && result.last))
        else $error("closing compare result not presented");

endmodule

`default_nettype wire

// ===== src/hwmf_ram.sv =====
// hwmf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hwmf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/hwmf_ctrl.sv =====
// hwmf_ctrl: command sequencer (idle / compare walk / closing result).
// Depends on hwmf_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hwmf_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire hwmf_pkg::stat_t stat,
    output hwmf_pkg::ctl_t       ctl
);

    typedef enum logic [1:0] {
        IDLE,
        WALK,
        FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_ready = (state_reg == IDLE) && stat.out_free;

    always_comb
    begin
        ctl.accept = item_valid && item_ready;
        ctl.walk = (state_reg == WALK);
        ctl.flush = (state_reg == FLUSH) && stat.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE:
            begin
                if (ctl.accept && stat.is_compare)
                begin
                    state_next = WALK;
                end
            end
            WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = FLUSH;
                end
            end
            FLUSH:
            begin
                if (stat.out_free)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/hwmf_dp.sv =====
// hwmf_dp: window pointers, site store, compare walk and output register.
// Depends on hwmf_pkg and hwmf_ram.
`timescale 1ns / 1ps
`default_nettype none

module hwmf_dp #(
    parameter int NUM_SAMPLES = 32,
    parameter int WINDOW_SITES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hwmf_pkg::item_t   item,
    input  wire hwmf_pkg::ctl_t    ctl,
    output hwmf_pkg::stat_t        stat,
    output hwmf_pkg::result_t      result,
    output logic                   result_valid,
    input  wire logic              result_ready
);

    localparam int AW = $clog2(WINDOW_SITES);
    localparam int CW = $clog2(WINDOW_SITES + 1);
    localparam int SUM_W = AW + 1;
    localparam int DW = 2 * NUM_SAMPLES;
    localparam int TRACK_W = hwmf_pkg::TRACK_W;
    localparam int INDEX_W = hwmf_pkg::INDEX_W;
    localparam int SAMPLE_W = hwmf_pkg::SAMPLE_W;

    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [AW-1:0]       chk_idx_reg, chk_idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic                out_valid_reg, out_valid_next;
    hwmf_pkg::result_t   out_reg, out_next;
    logic [SAMPLE_W-1:0] s1_reg, s2_reg;
    logic                t1_reg, t2_reg;

    logic                we, re;
    logic [AW-1:0]       waddr, raddr;
    logic [DW-1:0]       wdata, rdata;
    logic [SUM_W-1:0]    wsum, rsum;
    logic [TRACK_W-1:0]  lo_bits, hi_bits;
    logic                bit_one, bit_two, mis, stall, out_free, can_issue;

    hwmf_ram #(
        .WIDTH(DW),
        .DEPTH(WINDOW_SITES)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    // slot = (oldest + offset) mod window; offset never exceeds the window
    assign wsum = SUM_W'(oldest_reg) + SUM_W'(held_reg);
    assign rsum = SUM_W'(oldest_reg) + SUM_W'(rd_idx_reg);
    assign waddr = (wsum >= SUM_W'(WINDOW_SITES)) ?
                   AW'(wsum - SUM_W'(WINDOW_SITES)) : wsum[AW-1:0];
    assign raddr = (rsum >= SUM_W'(WINDOW_SITES)) ?
                   AW'(rsum - SUM_W'(WINDOW_SITES)) : rsum[AW-1:0];
    assign wdata = {item.second_track_bits[NUM_SAMPLES-1:0],
                    item.first_track_bits[NUM_SAMPLES-1:0]};

    // samples beyond NUM_SAMPLES land in the zero extension
    assign lo_bits = TRACK_W'(rdata[NUM_SAMPLES-1:0]);
    assign hi_bits = TRACK_W'(rdata[DW-1:NUM_SAMPLES]);
    assign bit_one = t1_reg ? hi_bits[s1_reg] : lo_bits[s1_reg];
    assign bit_two = t2_reg ? hi_bits[s2_reg] : lo_bits[s2_reg];

    assign out_free = !out_valid_reg || result_ready;
    assign mis = chk_valid_reg && (bit_one != bit_two);
    assign stall = mis && pend_valid_reg && !out_free;
    assign can_issue = rd_idx_reg < held_reg;

    assign we = ctl.accept && (item.command == hwmf_pkg::CMD_APPEND)
                && (held_reg != CW'(WINDOW_SITES));
    assign re = ctl.walk && !stall && can_issue;

    always_comb
    begin
        stat.out_free = out_free;
        stat.walk_done = !can_issue && !chk_valid_reg;
        stat.is_compare = (item.command == hwmf_pkg::CMD_COMPARE);
    end

    always_comb
    begin
        oldest_next = oldest_reg;
        held_next = held_reg;
        rd_idx_next = rd_idx_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next = pend_idx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next = out_reg;

        if (ctl.accept)
        begin
            case (item.command)
                hwmf_pkg::CMD_APPEND:
                begin
                    out_valid_next = 1'b1;
                    out_next = '{site_index: '0, status: hwmf_pkg::ST_APPENDED, last: 1'b1};
                    if (held_reg == CW'(WINDOW_SITES))
                    begin
                        out_next.status = hwmf_pkg::ST_FULL;
                    end
                    else
                    begin
                        held_next = held_reg + CW'(1);
                    end
                end
                hwmf_pkg::CMD_REMOVE:
                begin
                    out_valid_next = 1'b1;
                    out_next = '{site_index: '0, status: hwmf_pkg::ST_REMOVED, last: 1'b1};
                    if (held_reg == '0)
                    begin
                        out_next.status = hwmf_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        held_next = held_reg - CW'(1);
                        oldest_next = (oldest_reg == AW'(WINDOW_SITES - 1)) ?
                                      '0 : oldest_reg + AW'(1);
                    end
                end
                hwmf_pkg::CMD_COMPARE:
                begin
                    rd_idx_next = '0;
                    chk_valid_next = 1'b0;
                    pend_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.walk && !stall)
        begin
            chk_valid_next = can_issue;
            chk_idx_next = rd_idx_reg[AW-1:0];
            if (can_issue)
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            // hold one mismatch back so the final one can carry last
            if (mis)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{site_index: INDEX_W'(pend_idx_reg),
                                 status: hwmf_pkg::ST_MISMATCH, last: 1'b0};
                end
                pend_valid_next = 1'b1;
                pend_idx_next = chk_idx_reg;
            end
        end

        if (ctl.flush)
        begin
            out_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next = '{site_index: INDEX_W'(pend_idx_reg),
                             status: hwmf_pkg::ST_MISMATCH, last: 1'b1};
            end
            else
            begin
                out_next = '{site_index: '0, status: hwmf_pkg::ST_NO_MISMATCH, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg <= '0;
            rd_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            held_reg <= held_next;
            rd_idx_reg <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        pend_idx_reg <= pend_idx_next;
        out_reg <= out_next;
        if (ctl.accept && (item.command == hwmf_pkg::CMD_COMPARE))
        begin
            s1_reg <= item.sample_one;
            t1_reg <= item.track_one;
            s2_reg <= item.sample_two;
            t2_reg <= item.track_two;
        end
    end

    assign result = out_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire
